[rtl/ipdt_pkg.sv]
// ----------------------------------------------------------------------------
// ipdt_pkg
// Shared types and constants of the pulse-distance IR frame transmitter.
// ----------------------------------------------------------------------------
package ipdt_pkg;

    // Bits in each field of the frame (address, inverse, data, inverse)
    localparam int unsigned FIELD_BITS = 8;

    // Off units after the mark of a one bit and of a zero bit
    localparam int unsigned ONE_SPACE_UNITS  = 3;
    localparam int unsigned ZERO_SPACE_UNITS = 1;

    // Configuration register map, byte addresses
    localparam int unsigned APB_ADDR_W       = 3;
    localparam int unsigned APB_DATA_W       = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_DEVICE_ADDRESS = 3'd0;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_ADDR  = 3'd2,
        PH_DATA  = 3'd3,
        PH_STOP  = 3'd4
    } phase_t;

endpackage

[rtl/ipdt_in_if.sv]
// ----------------------------------------------------------------------------
// ipdt_in_if
// Input channel: one beat per time unit, with request and data byte.
// ----------------------------------------------------------------------------
interface ipdt_in_if;
    logic       valid;
    logic       ready;
    logic       send_request;
    logic [7:0] data_byte;

    modport source (output valid, output send_request, output data_byte, input ready);
    modport sink   (input valid, input send_request, input data_byte, output ready);
endinterface

[rtl/ipdt_out_if.sv]
// ----------------------------------------------------------------------------
// ipdt_out_if
// Output channel: one beat per time unit, with carrier enable and status.
// ----------------------------------------------------------------------------
interface ipdt_out_if;
    logic       valid;
    logic       ready;
    logic       carrier_on;
    logic [2:0] frame_phase;
    logic       frame_done;

    modport source (output valid, output carrier_on, output frame_phase,
                    output frame_done, input ready);
    modport sink   (input valid, input carrier_on, input frame_phase,
                    input frame_done, output ready);
endinterface

[rtl/ir_pulse_distance_frame_tx.sv]
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_tx
// Pulse-distance infrared frame transmitter, one input beat per time unit.
// ----------------------------------------------------------------------------
// Each beat on cmd is one time unit and yields exactly one beat on tx, whose
// carrier_on gates the modulated carrier for that unit. A beat with
// send_request set while idle starts a frame and latches data_byte; that same
// unit already carries the first mark of the start burst. The frame is a start
// burst (START_UNITS on, START_UNITS/2 off), then device_address, its inverse,
// the data byte and its inverse, each LSB first (a zero bit is one unit on and
// one off, a one bit is one unit on and three off), then a stop of one unit on
// and one off, with frame_done raised on that last unit. Requests while busy
// are ignored. device_address is read live on every unit, so write it only
// between frames. The block takes one beat per clock cycle: the state update
// and the result both come from one level of logic into the output register,
// and cmd is held off only while a finished tx beat waits to be taken.
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_tx #(
    parameter int unsigned START_UNITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    ipdt_in_if.sink                            cmd,
    ipdt_out_if.source                         tx,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ipdt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ipdt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ipdt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    // Unit counter is wide enough to hold the full burst length
    localparam int unsigned CNT_W      = $clog2(START_UNITS + 1);
    localparam int unsigned HALF_UNITS = START_UNITS / 2;
    localparam int unsigned BIT_W      = $clog2(ipdt_pkg::FIELD_BITS);

    // ------------------------------------------------------------------
    // Configuration: a single address register
    // ------------------------------------------------------------------
    logic [7:0] device_address_reg;
    logic       cfg_write;
    logic       cfg_hit;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    // Word decode: low byte-address bits are ignored
    assign cfg_hit   = (paddr[ipdt_pkg::APB_ADDR_W-1:2] ==
                        ipdt_pkg::ADDR_DEVICE_ADDRESS[ipdt_pkg::APB_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= 8'd0;
        end
        else if (cfg_write && cfg_hit)
        begin
            device_address_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (cfg_hit)
        begin
            prdata = {{(ipdt_pkg::APB_DATA_W-8){1'b0}}, device_address_reg};
        end
    end

    // ------------------------------------------------------------------
    // Frame state and output register
    // ------------------------------------------------------------------
    ipdt_pkg::phase_t   phase_reg, phase_next;
    logic [CNT_W-1:0]   unit_count_reg, unit_count_next;
    logic [BIT_W-1:0]   bit_position_reg, bit_position_next;
    logic               inverse_pass_reg, inverse_pass_next;
    logic               burst_part_reg, burst_part_next;
    logic [7:0]         held_byte_reg, held_byte_next;

    logic               out_valid_reg, out_valid_next;
    logic               carrier_reg, carrier_next;
    logic [2:0]         shown_reg, shown_next;
    logic               done_reg, done_next;

    logic               accept_in;

    // Take a new beat whenever the output register is free or being drained
    assign cmd.ready = !out_valid_reg || tx.ready;
    assign accept_in = cmd.valid && cmd.ready;

    assign tx.valid       = out_valid_reg;
    assign tx.carrier_on  = carrier_reg;
    assign tx.frame_phase = shown_reg;
    assign tx.frame_done  = done_reg;

    always_comb
    begin
        logic [7:0]       field_byte;
        logic             bit_val;
        logic [CNT_W-1:0] last_unit;
        logic [CNT_W-1:0] cnt_inc;

        phase_next        = phase_reg;
        unit_count_next   = unit_count_reg;
        bit_position_next = bit_position_reg;
        inverse_pass_next = inverse_pass_reg;
        burst_part_next   = burst_part_reg;
        held_byte_next    = held_byte_reg;
        carrier_next      = 1'b0;
        done_next         = 1'b0;

        // Start a frame from idle; the first burst unit goes out this beat
        if (phase_reg == ipdt_pkg::PH_IDLE)
        begin
            if (cmd.send_request)
            begin
                held_byte_next    = cmd.data_byte;
                phase_next        = ipdt_pkg::PH_START;
                burst_part_next   = 1'b1;
                unit_count_next   = '0;
                bit_position_next = '0;
                inverse_pass_next = 1'b0;
            end
        end

        shown_next = phase_next;

        field_byte = (phase_next == ipdt_pkg::PH_ADDR) ? device_address_reg
                                                       : held_byte_next;
        bit_val    = field_byte[bit_position_next] ^ inverse_pass_next;
        last_unit  = bit_val ? CNT_W'(ipdt_pkg::ONE_SPACE_UNITS)
                             : CNT_W'(ipdt_pkg::ZERO_SPACE_UNITS);
        cnt_inc    = unit_count_next + CNT_W'(1);

        unique case (phase_next)
            ipdt_pkg::PH_START:
            begin
                carrier_next = burst_part_next;
                if (burst_part_next)
                begin
                    if (cnt_inc >= CNT_W'(START_UNITS))
                    begin
                        burst_part_next = 1'b0;
                        unit_count_next = '0;
                    end
                    else
                    begin
                        unit_count_next = cnt_inc;
                    end
                end
                else if (cnt_inc >= CNT_W'(HALF_UNITS))
                begin
                    burst_part_next   = 1'b1;
                    unit_count_next   = '0;
                    bit_position_next = '0;
                    inverse_pass_next = 1'b0;
                    phase_next        = ipdt_pkg::PH_ADDR;
                end
                else
                begin
                    unit_count_next = cnt_inc;
                end
            end
            ipdt_pkg::PH_ADDR,
            ipdt_pkg::PH_DATA:
            begin
                // Mark on the first unit of a bit, space for the rest
                carrier_next = (unit_count_next == '0);
                if (unit_count_next >= last_unit)
                begin
                    unit_count_next = '0;
                    if (bit_position_next == BIT_W'(ipdt_pkg::FIELD_BITS - 1))
                    begin
                        bit_position_next = '0;
                        if (inverse_pass_next)
                        begin
                            inverse_pass_next = 1'b0;
                            phase_next = (phase_next == ipdt_pkg::PH_ADDR)
                                         ? ipdt_pkg::PH_DATA : ipdt_pkg::PH_STOP;
                        end
                        else
                        begin
                            inverse_pass_next = 1'b1;
                        end
                    end
                    else
                    begin
                        bit_position_next = bit_position_next + BIT_W'(1);
                    end
                end
                else
                begin
                    unit_count_next = cnt_inc;
                end
            end
            ipdt_pkg::PH_STOP:
            begin
                if (unit_count_next == '0)
                begin
                    carrier_next    = 1'b1;
                    unit_count_next = CNT_W'(1);
                end
                else
                begin
                    unit_count_next = '0;
                    done_next       = 1'b1;
                    phase_next      = ipdt_pkg::PH_IDLE;
                end
            end
            default:
            begin
                // Idle: carrier off, nothing to advance
                phase_next = ipdt_pkg::PH_IDLE;
            end
        endcase

        // Hold the result until taken; load a fresh one on every accepted beat
        if (accept_in)
        begin
            out_valid_next = 1'b1;
        end
        else if (tx.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= ipdt_pkg::PH_IDLE;
            unit_count_reg   <= '0;
            bit_position_reg <= '0;
            inverse_pass_reg <= 1'b0;
            burst_part_reg   <= 1'b1;
            held_byte_reg    <= 8'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept_in)
            begin
                phase_reg        <= phase_next;
                unit_count_reg   <= unit_count_next;
                bit_position_reg <= bit_position_next;
                inverse_pass_reg <= inverse_pass_next;
                burst_part_reg   <= burst_part_next;
                held_byte_reg    <= held_byte_next;
            end
        end
    end

    // Result payload: no reset needed, qualified by out_valid_reg
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            carrier_reg <= carrier_next;
            shown_reg   <= shown_next;
            done_reg    <= done_next;
        end
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pulse-distance IR frame transmitter: queued
// time units go in on cmd, every tx beat is checked against a unit-by-unit
// prediction of the frame state, and device_address is written over APB.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned BURST_UNITS = 16;
    // A frame always lasts the same number of units: each field and its
    // inverse together spend (1+ZERO) + (1+ONE) units on every bit position.
    localparam int unsigned FRAME_UNITS = BURST_UNITS + BURST_UNITS / 2
        + 2 * ipdt_pkg::FIELD_BITS
            * (2 + ipdt_pkg::ONE_SPACE_UNITS + ipdt_pkg::ZERO_SPACE_UNITS)
        + 2;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned LONG_HOLD   = 60;
    localparam int unsigned TAIL_CYCLES = 20;

    typedef struct packed {
        logic       send_request;
        logic [7:0] data_byte;
    } cmd_beat_t;

    typedef struct packed {
        logic       carrier_on;
        logic [2:0] frame_phase;
        logic       frame_done;
    } tx_beat_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ipdt_pkg::APB_ADDR_W-1:0] paddr;
    logic [ipdt_pkg::APB_DATA_W-1:0] pwdata;
    logic [ipdt_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    ipdt_in_if  cmd_ch ();
    ipdt_out_if tx_ch ();

    ir_pulse_distance_frame_tx #(
        .START_UNITS (BURST_UNITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .tx      (tx_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Units waiting to be driven on cmd, and tx beats still owed by the block
    cmd_beat_t   cmd_pend_q[$];
    tx_beat_t    tx_expect_q[$];
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles   = 0;

    // Mirror of the transmitter state, stepped once per accepted cmd beat
    ipdt_pkg::phase_t tx_phase;
    logic [6:0] unit_cnt;
    logic [2:0] bit_idx;
    logic       inv_pass;
    logic       burst_on;
    logic [7:0] latched_byte;
    logic [7:0] dev_addr;

    // Knobs for both sides, changed by the sequence only at rising edges
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    bit          hold_req     = 0;
    bit          cmd_took     = 0;
    int unsigned src_gap      = 0;
    int unsigned snk_gap      = 0;
    int unsigned hold_left    = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: step the frame state by one time unit and return the
    // tx beat that this unit must produce.
    // ------------------------------------------------------------------
    task automatic advance_frame(input cmd_beat_t c, output tx_beat_t r);
        logic [7:0] field;
        logic       bit_val;
        logic [6:0] space_end;
        r.carrier_on = 1'b0;
        r.frame_done = 1'b0;
        // Only an idle unit can start a frame; busy requests fall through
        if (tx_phase == ipdt_pkg::PH_IDLE || tx_phase > ipdt_pkg::PH_STOP)
        begin
            tx_phase = ipdt_pkg::PH_IDLE;
            if (c.send_request)
            begin
                latched_byte = c.data_byte;
                tx_phase     = ipdt_pkg::PH_START;
                burst_on     = 1'b1;
                unit_cnt     = '0;
                bit_idx      = '0;
                inv_pass     = 1'b0;
            end
        end
        r.frame_phase = tx_phase;
        case (tx_phase)
            ipdt_pkg::PH_START:
            begin
                r.carrier_on = burst_on;
                unit_cnt     = unit_cnt + 7'd1;
                if (burst_on)
                begin
                    if (unit_cnt >= BURST_UNITS)
                    begin
                        burst_on = 1'b0;
                        unit_cnt = '0;
                    end
                end
                else if (unit_cnt >= BURST_UNITS / 2)
                begin
                    burst_on = 1'b1;
                    unit_cnt = '0;
                    bit_idx  = '0;
                    inv_pass = 1'b0;
                    tx_phase = ipdt_pkg::PH_ADDR;
                end
            end
            ipdt_pkg::PH_ADDR, ipdt_pkg::PH_DATA:
            begin
                // The address is read live on every unit
                field        = (tx_phase == ipdt_pkg::PH_ADDR) ? dev_addr : latched_byte;
                bit_val      = field[bit_idx] ^ inv_pass;
                space_end    = bit_val ? 7'(ipdt_pkg::ONE_SPACE_UNITS)
                                       : 7'(ipdt_pkg::ZERO_SPACE_UNITS);
                r.carrier_on = (unit_cnt == 0);
                if (unit_cnt >= space_end)
                begin
                    unit_cnt = '0;
                    if (bit_idx >= ipdt_pkg::FIELD_BITS - 1)
                    begin
                        bit_idx = '0;
                        if (inv_pass)
                        begin
                            inv_pass = 1'b0;
                            tx_phase = (tx_phase == ipdt_pkg::PH_ADDR)
                                       ? ipdt_pkg::PH_DATA : ipdt_pkg::PH_STOP;
                        end
                        else
                        begin
                            inv_pass = 1'b1;
                        end
                    end
                    else
                    begin
                        bit_idx = bit_idx + 3'd1;
                    end
                end
                else
                begin
                    unit_cnt = unit_cnt + 7'd1;
                end
            end
            ipdt_pkg::PH_STOP:
            begin
                if (unit_cnt == 0)
                begin
                    r.carrier_on = 1'b1;
                    unit_cnt     = 7'd1;
                end
                else
                begin
                    unit_cnt     = '0;
                    r.frame_done = 1'b1;
                    tx_phase     = ipdt_pkg::PH_IDLE;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Source driver: advance cmd at the falling edge. Hold an offered beat
    // until it is taken, otherwise idle in random bursts.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic      offer;
        cmd_beat_t beat;
        beat = cmd_beat_t'($urandom_range(0, 511));
        if (!rst_n)
        begin
            offer = 1'b0;
        end
        else if (cmd_ch.valid && !cmd_took)
        begin
            offer = 1'b1;
        end
        else if (src_gap > 0)
        begin
            src_gap--;
            offer = 1'b0;
        end
        else if (cmd_pend_q.size() == 0)
        begin
            offer = 1'b0;
        end
        else if (src_idle_pct != 0 && $urandom_range(1, 100) <= src_idle_pct)
        begin
            src_gap = $urandom_range(0, 10);
            offer   = 1'b0;
        end
        else
        begin
            offer = 1'b1;
        end
        if (offer)
            beat = cmd_pend_q[0];
        cmd_took               = 1'b0;
        cmd_ch.valid        <= offer;
        cmd_ch.send_request <= beat.send_request;
        cmd_ch.data_byte    <= beat.data_byte;
    end

    // ------------------------------------------------------------------
    // Sink driver: drop ready in random bursts, or for one long hold when
    // the sequence asks for it, counted here in cycles.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic take;
        if (hold_req)
        begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (!rst_n)
        begin
            take = 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            take = 1'b0;
        end
        else if (snk_gap > 0)
        begin
            snk_gap--;
            take = 1'b0;
        end
        else if (snk_idle_pct != 0 && $urandom_range(1, 100) <= snk_idle_pct)
        begin
            snk_gap = $urandom_range(0, 10);
            take    = 1'b0;
        end
        else
        begin
            take = 1'b1;
        end
        tx_ch.ready <= take;
    end

    // ------------------------------------------------------------------
    // Monitor: at the rising edge check a taken tx beat against the oldest
    // expectation first, then step the predictor for a taken cmd beat, and
    // track register writes so the predictor sees the live address.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        tx_beat_t  got;
        tx_beat_t  want;
        cmd_beat_t beat;
        if (rst_n)
        begin
            if (tx_ch.valid && tx_ch.ready)
            begin
                got = {tx_ch.carrier_on, tx_ch.frame_phase, tx_ch.frame_done};
                if (tx_expect_q.size() == 0)
                begin
                    $display("%0t: tx beat with none expected: %s", $time,
                             $sformatf("carrier_on=%0b phase=%0d done=%0b",
                                       got.carrier_on, got.frame_phase, got.frame_done));
                    mismatch_count++;
                end
                else
                begin
                    want = tx_expect_q.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: tx mismatch: expected %s, actual %s", $time,
                                 $sformatf("carrier_on=%0b phase=%0d done=%0b",
                                           want.carrier_on, want.frame_phase,
                                           want.frame_done),
                                 $sformatf("carrier_on=%0b phase=%0d done=%0b",
                                           got.carrier_on, got.frame_phase,
                                           got.frame_done));
                        mismatch_count++;
                    end
                end
            end
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                beat = cmd_pend_q.pop_front();
                advance_frame(beat, want);
                tx_expect_q.push_back(want);
                cmd_took = 1'b1;
            end
            if (psel && penable && pwrite && pready
                && paddr == ipdt_pkg::ADDR_DEVICE_ADDRESS)
                dev_addr = pwdata[7:0];
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (tx_ch.valid && tx_ch.ready)
            || (psel && penable))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("ir_pulse_distance_frame_tx verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence helpers. Queue units only from a rising-edge time step.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [ipdt_pkg::APB_ADDR_W-1:0] addr,
                             input logic [7:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {{(ipdt_pkg::APB_DATA_W - 8){1'b0}}, value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic queue_idle(input int unsigned units);
        cmd_beat_t c;
        repeat (units)
        begin
            c.send_request = 1'b0;
            c.data_byte    = 8'($urandom_range(0, 255));
            cmd_pend_q.push_back(c);
        end
    endtask

    // One whole frame: the request unit, then the busy units, some of which
    // carry requests that must be ignored
    task automatic queue_frame(input logic [7:0] payload, input int unsigned busy_pct);
        cmd_beat_t c;
        c.send_request = 1'b1;
        c.data_byte    = payload;
        cmd_pend_q.push_back(c);
        repeat (FRAME_UNITS - 1)
        begin
            c.send_request = ($urandom_range(1, 100) <= busy_pct);
            c.data_byte    = 8'($urandom_range(0, 255));
            cmd_pend_q.push_back(c);
        end
    endtask

    // Mostly well-formed frames with random content, short idle runs between
    // them, and now and then a few stray units that knock frames off step
    task automatic queue_traffic(input int unsigned frames);
        cmd_beat_t c;
        repeat (frames)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    c = cmd_beat_t'($urandom_range(0, 511));
                    cmd_pend_q.push_back(c);
                end
            end
            queue_idle($urandom_range(0, 4));
            queue_frame(8'($urandom_range(0, 255)), 20);
        end
    endtask

    // Hold the sender until every queued unit is taken and every beat is in
    task automatic wait_drain();
        do
            @(negedge clk);
        while (cmd_pend_q.size() != 0 || tx_expect_q.size() != 0 || cmd_ch.valid);
    endtask

    // Drain, then pad with idle units until the frame in flight has ended
    task automatic settle_frame();
        wait_drain();
        while (tx_phase != ipdt_pkg::PH_IDLE)
        begin
            @(posedge clk);
            queue_idle(16);
            wait_drain();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        cmd_beat_t c;
        clk                 = 1'b0;
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.send_request = 1'b0;
        cmd_ch.data_byte    = '0;
        tx_ch.ready         = 1'b0;
        tx_phase            = ipdt_pkg::PH_IDLE;
        unit_cnt            = '0;
        bit_idx             = '0;
        inv_pass            = 1'b0;
        burst_on            = 1'b1;
        latched_byte        = '0;
        dev_addr            = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Address zero, data zero, with every busy unit requesting 0xFF that
        // must not be latched, then a back-to-back frame of 0xFF
        write_reg(ipdt_pkg::ADDR_DEVICE_ADDRESS, 8'h00);
        @(posedge clk);
        src_idle_pct = 15;
        snk_idle_pct = 15;
        queue_idle(3);
        c.send_request = 1'b1;
        c.data_byte    = 8'h00;
        cmd_pend_q.push_back(c);
        repeat (FRAME_UNITS - 1)
        begin
            c.data_byte = 8'hFF;
            cmd_pend_q.push_back(c);
        end
        queue_frame(8'hFF, 0);
        queue_idle(2);
        settle_frame();

        // All-ones address
        write_reg(ipdt_pkg::ADDR_DEVICE_ADDRESS, 8'hFF);
        @(posedge clk);
        queue_frame(8'h5A, 50);
        queue_idle(1);
        settle_frame();

        // Change the address part way into the address field of a frame
        write_reg(ipdt_pkg::ADDR_DEVICE_ADDRESS, 8'h96);
        @(posedge clk);
        c.send_request = 1'b1;
        c.data_byte    = 8'hC3;
        cmd_pend_q.push_back(c);
        queue_idle(40);
        wait_drain();
        write_reg(ipdt_pkg::ADDR_DEVICE_ADDRESS, 8'h3C);
        @(posedge clk);
        queue_idle(81);
        settle_frame();

        // Random traffic with idling on both sides
        write_reg(ipdt_pkg::ADDR_DEVICE_ADDRESS, 8'($urandom_range(0, 255)));
        @(posedge clk);
        src_idle_pct = 20;
        snk_idle_pct = 20;
        queue_traffic(2);
        settle_frame();

        // Long receiver hold while the sender keeps offering beats
        write_reg(ipdt_pkg::ADDR_DEVICE_ADDRESS, 8'($urandom_range(0, 255)));
        @(posedge clk);
        src_idle_pct = 0;
        snk_idle_pct = 10;
        hold_req     = 1'b1;
        queue_traffic(2);
        settle_frame();

        write_reg(ipdt_pkg::ADDR_DEVICE_ADDRESS, 8'($urandom_range(0, 255)));
        @(posedge clk);
        src_idle_pct = 8;
        snk_idle_pct = 30;
        queue_traffic(2);
        settle_frame();

        // Last stretch runs flat out on both sides
        write_reg(ipdt_pkg::ADDR_DEVICE_ADDRESS, 8'($urandom_range(0, 255)));
        @(posedge clk);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        queue_traffic(2);
        settle_frame();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (tx_expect_q.size() != 0)
        begin
            $display("%0t: %0d tx beats still expected at end", $time, tx_expect_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("ir_pulse_distance_frame_tx verification clean");
        else
            $display("ir_pulse_distance_frame_tx verification failed");
        $finish;
    end
endmodule
